// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rstn, prop, msg)
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: rtl/bfpc_pkg.sv
package bfpc_pkg;

  // Byte count that the two pattern fields carry.
  localparam int PATTERN_BYTES = 16;

  // Command codes on the opcode field.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FIND  = 2'd2,
    OP_SPARE = 2'd3
  } bfpc_op_e;

  // Control from the scan sequencer to the pattern matcher.
  typedef struct packed {
    logic       load;   // latch a new pattern and clear the window
    logic       shift;  // shift one stored byte into the window
    logic [7:0] data;   // byte shifted in
  } bfpc_match_ctrl_t;

endpackage

// File: rtl/bfpc_match.sv
module bfpc_match #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfpc_pkg::bfpc_match_ctrl_t  ctrl_i,
  input  logic [63:0]                 pattern_low_i,
  input  logic [63:0]                 pattern_high_i,
  input  logic [4:0]                  pattern_length_i,
  output logic                        hit_o
);
  import bfpc_pkg::*;

  localparam int WIN = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;

  // Pattern stored newest-first so that slot i lines up with window slot i.
  logic [8*WIN-1:0]           pat_q, pat_d;
  logic [WIN-1:0]             mask_q, mask_d;
  logic [8*WIN-1:0]           win_q, win_n;
  logic [WIN-1:0]             wvld_q, wvld_n;
  logic [8*PATTERN_BYTES-1:0] pat_all;
  logic [4:0]                 idx;
  logic                       all_eq;

  // Align the pattern so that its last byte meets the newest window byte.
  always_comb begin
    pat_all = {pattern_high_i, pattern_low_i};
    pat_d   = pat_q;
    mask_d  = mask_q;
    idx     = '0;
    if (ctrl_i.load) begin
      for (int i = 0; i < WIN; i++) begin
        idx = pattern_length_i - 5'd1 - 5'(i);
        mask_d[i] = (5'(i) < pattern_length_i);
        pat_d[8*i +: 8] = mask_d[i] ? pat_all[8*idx[3:0] +: 8] : 8'd0;
      end
    end
  end

  // Window after the byte of this cycle has been shifted in.
  always_comb begin
    win_n  = (8*WIN)'({win_q, ctrl_i.data});
    wvld_n = WIN'({wvld_q, 1'b1});
  end

  // Compare every aligned slot of the window at once.
  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      all_eq &= !mask_q[i] || (wvld_n[i] && (win_n[8*i +: 8] == pat_q[8*i +: 8]));
    end
    hit_o = ctrl_i.shift && all_eq;
  end

  // Slot masks and window fill marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      wvld_q <= '0;
    end else begin
      mask_q <= mask_d;
      if (ctrl_i.load) begin
        wvld_q <= '0;
      end else if (ctrl_i.shift) begin
        wvld_q <= wvld_n;
      end
    end
  end

  // Pattern and window bytes.
  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    if (ctrl_i.shift) begin
      win_q <= win_n;
    end
  end

endmodule

// File: rtl/byte_fifo_with_pattern_consume.sv
// Receive byte ring buffer with pattern consume.
//
// Commands enter on start with opcode_i and its operands; a command is taken
// at a rising edge where start is high and busy is low. Each command yields
// exactly one result, shown for one cycle while done_o is high; the receiver
// cannot stall, so results must be taken as they appear.
// Push: result in the next cycle; busy stays low, so pushes can follow every
// cycle. When the ring already holds DEPTH-1 bytes the oldest is dropped and
// overwrote_o is set.
// Pop: the byte is read through the registered memory port, then returned
// from the pop state; an empty ring answers in the next cycle with read_valid_o low.
// Find: the stored bytes are read from the oldest through the single memory
// read port, one byte per cycle, into a window compared against the pattern.
// The scan stops early on a hit, else once the newest stored byte is compared.
// An invalid or over-long pattern answers in the next cycle.
// Reset empties the ring (both indices zero); the byte memory is not cleared.
module byte_fifo_with_pattern_consume #(
  parameter int DEPTH       = 512,
  parameter int MAX_PATTERN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  push_byte_i,
  input  logic [63:0] pattern_low_i,
  input  logic [63:0] pattern_high_i,
  input  logic [4:0]  pattern_length_i,
  output logic        done_o,
  output logic [7:0]  read_byte_o,
  output logic        read_valid_o,
  output logic        found_o,
  output logic        overwrote_o,
  output logic [8:0]  fill_count_o
);
  import bfpc_pkg::*;

`include "assert_macros.svh"

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = (AW > 9) ? AW : 9;
  localparam int WIN = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW-1:0] sp_q, sp_d, ca_q, ca_d;
  logic          rvld_q, rvld_d;
  logic [7:0]    byte_store_q [DEPTH];
  logic [7:0]    rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] wr_inc, rd_inc, ca_inc;
  logic [CW-1:0] fill_now, fill_new;
  logic          accept, plen_ok, hit;

  logic          done_q, done_d;
  logic [7:0]    read_byte_q, read_byte_d;
  logic          read_valid_q, read_valid_d;
  logic          found_q, found_d;
  logic          overwrote_q, overwrote_d;
  logic [8:0]    fill_q;

  bfpc_match_ctrl_t mctrl;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
    return (x == AW'(DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [CW-1:0] ring_fill(input logic [AW-1:0] w,
                                              input logic [AW-1:0] r);
    logic [AW:0] sum;
    sum = {1'b0, w} + (AW + 1)'(DEPTH) - {1'b0, r};
    return (w >= r) ? CW'(w - r) : CW'(sum[AW-1:0]);
  endfunction

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign wr_inc  = ring_inc(wr_q);
  assign rd_inc  = ring_inc(rd_q);
  assign ca_inc  = ring_inc(ca_q);
  assign fill_now = ring_fill(wr_q, rd_q);
  assign fill_new = ring_fill(wr_d, rd_d);
  assign plen_ok = (pattern_length_i != 5'd0) && (pattern_length_i <= 5'(WIN))
                   && (fill_now >= CW'(pattern_length_i));

  // Command sequencer: push, pop read, and the byte-per-cycle find scan.
  always_comb begin
    state_d      = state_q;
    wr_d         = wr_q;
    rd_d         = rd_q;
    sp_d         = sp_q;
    ca_d         = ca_q;
    rvld_d       = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = rd_q;
    mctrl.load   = 1'b0;
    mctrl.shift  = 1'b0;
    mctrl.data   = rdata_q;
    done_d       = 1'b0;
    read_byte_d  = 8'd0;
    read_valid_d = 1'b0;
    found_d      = 1'b0;
    overwrote_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_PUSH: begin
              mem_we = 1'b1;
              wr_d   = wr_inc;
              if (wr_inc == rd_q) begin
                rd_d        = rd_inc;
                overwrote_d = 1'b1;
              end
              done_d = 1'b1;
            end
            OP_POP: begin
              if (wr_q != rd_q) begin
                mem_re  = 1'b1;
                state_d = ST_POP;
              end else begin
                done_d = 1'b1;
              end
            end
            OP_FIND: begin
              if (plen_ok) begin
                mctrl.load = 1'b1;
                sp_d       = rd_q;
                ca_d       = rd_q;
                state_d    = ST_SCAN;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        rd_d         = rd_inc;
        read_byte_d  = rdata_q;
        read_valid_d = 1'b1;
        done_d       = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        // Issue the next read while bytes remain.
        if (sp_q != wr_q) begin
          mem_re    = 1'b1;
          mem_raddr = sp_q;
          sp_d      = ring_inc(sp_q);
          rvld_d    = 1'b1;
        end
        // Consume the byte read in the previous cycle.
        if (rvld_q) begin
          mctrl.shift = 1'b1;
          ca_d        = ca_inc;
          if (hit) begin
            rd_d    = ca_inc;
            found_d = 1'b1;
            done_d  = 1'b1;
            rvld_d  = 1'b0;
            state_d = ST_IDLE;
          end else if (ca_inc == wr_q) begin
            done_d  = 1'b1;
            rvld_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  bfpc_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (mctrl),
    .pattern_low_i    (pattern_low_i),
    .pattern_high_i   (pattern_high_i),
    .pattern_length_i (pattern_length_i),
    .hit_o            (hit)
  );

  // Byte memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      byte_store_q[wr_q] <= push_byte_i;
    end
    if (mem_re) begin
      rdata_q <= byte_store_q[mem_raddr];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_q    <= '0;
      rd_q    <= '0;
      rvld_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      rvld_q  <= rvld_d;
      done_q  <= done_d;
    end
  end

  // Scan addresses and result payload.
  always_ff @(posedge clk_i) begin
    sp_q         <= sp_d;
    ca_q         <= ca_d;
    read_byte_q  <= read_byte_d;
    read_valid_q <= read_valid_d;
    found_q      <= found_d;
    overwrote_q  <= overwrote_d;
    fill_q       <= fill_new[8:0];
  end

  assign done_o       = done_q;
  assign read_byte_o  = read_byte_q;
  assign read_valid_o = read_valid_q;
  assign found_o      = found_q;
  assign overwrote_o  = overwrote_q;
  assign fill_count_o = fill_q;

  // A pop read is only started on a ring that holds data.
  `ASSERT_CLK(a_pop_nonempty, clk_i, rst_ni, (state_q == ST_POP) |-> (wr_q != rd_q), "pop with empty ring")
  // The scan never consumes past the newest byte.
  `ASSERT_CLK(a_scan_bound, clk_i, rst_ni, rvld_q |-> (ca_q != wr_q), "scan ran past write index")
  // A returned byte always comes from the pop read state.
  `ASSERT_CLK(a_pop_result, clk_i, rst_ni, (done_q && read_valid_q) |-> ($past(state_q) == ST_POP), "pop result without read")
  // Reset leaves the sequencer idle with no result pending.
  `ASSERT_CLK_ALWAYS(a_reset_idle, clk_i, (!rst_ni) |-> ((state_q == ST_IDLE) && !done_q), "not idle in reset")

endmodule
